### hw/rtl/dda_pkg.sv
// ----------------------------------------------------------------------------
// DDA ray caster package
// Shared constants, register codes, state encodings, config, queue entry and result types.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int MAP_SIDE  = 16;
    localparam int CELL_W    = $clog2(MAP_SIDE);
    localparam int MAP_BITS  = MAP_SIDE * MAP_SIDE;
    localparam int MAX_STEPS = 32;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);
    localparam int FRAC_W    = 12;
    localparam int ONE_CELL  = 1 << FRAC_W;
    // Boundary distance numerator grows by one cell per step.
    localparam int T_W       = $clog2(ONE_CELL * (MAX_STEPS + 1) + 1);
    localparam int ACC_W     = T_W + 16;
    localparam int N_W       = T_W + 15;

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam int REM_W     = 20;
    localparam int NUM_W     = 18;
    localparam int DCNT_W    = 5;
    localparam int DIST_STEPS = 16;
    localparam int H_STEPS    = 18;
    localparam int MIX_STEPS  = 8;

    localparam logic [9:0]  H_RESET    = 10'd240;
    localparam logic [15:0] RD_RESET   = 16'd4096;
    localparam logic [23:0] WALL_RESET = 24'hFAAFAF;
    localparam logic [23:0] FOG_RESET  = 24'h0064C8;

    typedef enum logic [2:0] {
        REG_MAP0  = 3'd0,
        REG_MAP1  = 3'd1,
        REG_MAP2  = 3'd2,
        REG_MAP3  = 3'd3,
        REG_HEIGHT = 3'd4,
        REG_RDIST = 3'd5,
        REG_WALL  = 3'd6,
        REG_FOG   = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_MULX,
        FR_MULY,
        FR_WALK,
        FR_PUSH
    } fr_state_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MUL,
        BK_DSET,
        BK_DDIV,
        BK_HSET,
        BK_HDIV,
        BK_MSET,
        BK_MDIV,
        BK_BLEND,
        BK_DONE
    } bk_state_t;

    typedef struct packed {
        logic [9:0]  screen_height;
        logic [15:0] render_distance;
        logic [23:0] wall_color;
        logic [23:0] fog_color;
    } cfg_t;

    typedef struct packed {
        logic              hit;
        logic              side;
        logic [CELL_W-1:0] cx;
        logic [CELL_W-1:0] cy;
        logic [T_W-1:0]    t;
        logic [15:0]       a;
        logic [14:0]       vc;
    } qent_t;

    typedef struct packed {
        logic              hit;
        logic              side;
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
        logic [15:0]       distance;
        logic [9:0]        draw_start;
        logic [9:0]        draw_end;
        logic [8:0]        fog_mix;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } res_t;

endpackage

### hw/rtl/dda_front.sv
// ----------------------------------------------------------------------------
// DDA front end
// Takes a ray request, sets up the boundary products, walks the map and pushes the result.
// ----------------------------------------------------------------------------
module dda_front
    import dda_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [15:0]         pos_x,
    input  logic [15:0]         pos_y,
    input  logic signed [15:0]  dir_x,
    input  logic signed [15:0]  dir_y,
    input  logic [14:0]         view_cos,
    input  logic [MAP_BITS-1:0] map_bits,
    output logic                q_push,
    output qent_t               q_data,
    input  logic                q_full
);

    fr_state_t         state_reg, state_next;
    logic [CELL_W-1:0] cx_reg, cy_reg;
    logic              sxn_reg, syn_reg, dxz_reg, dyz_reg;
    logic [T_W-1:0]    tx_reg, ty_reg;
    logic [15:0]       adx_reg, ady_reg;
    logic [ACC_W-1:0]  accx_reg, accy_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [14:0]       vc_reg;
    qent_t             ent_reg;

    logic              step_x, lim_x, lim_y, leave, wall, last, done;
    logic [CELL_W-1:0] ncx, ncy, tcx, tcy;

    always_comb
    begin
        step_x = !dxz_reg && (dyz_reg || (accx_reg < accy_reg));
        ncx    = sxn_reg ? cx_reg - 1'b1 : cx_reg + 1'b1;
        ncy    = syn_reg ? cy_reg - 1'b1 : cy_reg + 1'b1;
        lim_x  = sxn_reg ? (cx_reg == '0) : (cx_reg == CELL_W'(MAP_SIDE - 1));
        lim_y  = syn_reg ? (cy_reg == '0) : (cy_reg == CELL_W'(MAP_SIDE - 1));
        leave  = step_x ? lim_x : lim_y;
        tcx    = step_x ? ncx : cx_reg;
        tcy    = step_x ? cy_reg : ncy;
        wall   = map_bits[{tcy, tcx}];
        last   = (cnt_reg == STEP_W'(MAX_STEPS - 1));
        done   = leave || wall || last;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE: if (in_valid) state_next = FR_MULX;
            FR_MULX: state_next = FR_MULY;
            FR_MULY: state_next = FR_WALK;
            FR_WALK: if (done) state_next = FR_PUSH;
            FR_PUSH: if (!q_full) state_next = FR_IDLE;
            default: state_next = FR_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != FR_IDLE);
        q_push   = (state_reg == FR_PUSH) && !q_full;
        q_data   = ent_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            FR_IDLE:
            begin
                if (in_valid)
                begin
                    cx_reg  <= pos_x[15:12];
                    cy_reg  <= pos_y[15:12];
                    sxn_reg <= dir_x[15];
                    syn_reg <= dir_y[15];
                    dxz_reg <= (dir_x == 16'sd0);
                    dyz_reg <= (dir_y == 16'sd0);
                    adx_reg <= dir_x[15] ? 16'(-dir_x) : 16'(dir_x);
                    ady_reg <= dir_y[15] ? 16'(-dir_y) : 16'(dir_y);
                    tx_reg  <= dir_x[15] ? T_W'(pos_x[11:0])
                                         : T_W'(ONE_CELL) - T_W'(pos_x[11:0]);
                    ty_reg  <= dir_y[15] ? T_W'(pos_y[11:0])
                                         : T_W'(ONE_CELL) - T_W'(pos_y[11:0]);
                    vc_reg  <= view_cos;
                end
            end
            FR_MULX: accx_reg <= ACC_W'(tx_reg * ady_reg);
            FR_MULY:
            begin
                accy_reg <= ACC_W'(ty_reg * adx_reg);
                cnt_reg  <= '0;
            end
            FR_WALK:
            begin
                // Products advance by one cell times the other axis slope.
                if (step_x)
                begin
                    tx_reg   <= tx_reg + T_W'(ONE_CELL);
                    accx_reg <= accx_reg + (ACC_W'(ady_reg) << FRAC_W);
                    cx_reg   <= ncx;
                end
                else
                begin
                    ty_reg   <= ty_reg + T_W'(ONE_CELL);
                    accy_reg <= accy_reg + (ACC_W'(adx_reg) << FRAC_W);
                    cy_reg   <= ncy;
                end
                cnt_reg      <= cnt_reg + 1'b1;
                ent_reg.hit  <= wall && !leave;
                ent_reg.side <= !step_x;
                ent_reg.cx   <= tcx;
                ent_reg.cy   <= tcy;
                ent_reg.t    <= step_x ? tx_reg : ty_reg;
                ent_reg.a    <= step_x ? adx_reg : ady_reg;
                ent_reg.vc   <= vc_reg;
            end
            FR_PUSH: ;
            default: ;
        endcase
    end

endmodule

### hw/rtl/dda_fifo.sv
// ----------------------------------------------------------------------------
// DDA walk queue
// Small queue of walk results between the front end and the shading unit.
// ----------------------------------------------------------------------------
module dda_fifo
    import dda_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  qent_t push_data,
    output logic  full,
    input  logic  pop,
    output qent_t pop_data,
    output logic  nonempty
);

    qent_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_reg, rd_reg;
    logic [CNT_W-1:0]  cnt_reg;

    assign full     = (cnt_reg == CNT_W'(FIFO_DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            if (push && !pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= push_data;
    end

endmodule

### hw/rtl/dda_back.sv
// ----------------------------------------------------------------------------
// DDA shading unit
// Distance, wall height and fog weight through one serial divider; span and colour from them.
// ----------------------------------------------------------------------------
module dda_back
    import dda_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_valid,
    output logic  q_pop,
    input  qent_t q_data,
    input  cfg_t  cfg,
    output logic  out_valid,
    input  logic  out_stall,
    output res_t  res
);

    bk_state_t          state_reg, state_next;
    qent_t              ent_reg;
    logic [N_W-1:0]     n_reg;
    logic [15:0]        dist_reg;
    logic [17:0]        h_reg;
    logic [8:0]         mix_reg;
    logic [REM_W-1:0]   rem_reg, div_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [17:0]        quo_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    res_t               res_reg, out_reg;
    logic               out_valid_reg;

    logic               out_free, out_load, sat, ge, div_last;
    logic [REM_W:0]     r2;
    logic [REM_W-1:0]   rem_nx, dden;
    logic [17:0]        quo_nx;
    logic [16:0]        hh;
    logic [8:0]         half_h;
    logic [17:0]        bot;
    logic [9:0]         start_v, end_v;

    function automatic logic [7:0] blend(input logic [7:0] w, input logic [7:0] f,
                                         input logic [8:0] mix);
        logic [16:0] s;
        s = 17'(w * (9'd256 - mix)) + 17'(f * mix);
        return s[15:8];
    endfunction

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        dden     = {ent_reg.a, 4'b0000};
        sat      = (ent_reg.a == '0) || (REM_W'(n_reg[N_W-1:16]) >= dden);
        r2       = {rem_reg, num_reg[NUM_W-1]};
        ge       = (r2 >= {1'b0, div_reg});
        rem_nx   = ge ? REM_W'(r2 - {1'b0, div_reg}) : r2[REM_W-1:0];
        quo_nx   = {quo_reg[16:0], ge};
        div_last = (dcnt_reg == DCNT_W'(1));
        // Wall span around the screen centre; a huge h clamps both ends.
        hh       = h_reg[17:1];
        half_h   = cfg.screen_height[9:1];
        start_v  = (hh < 17'(half_h)) ? 10'(half_h - hh[8:0]) : 10'd0;
        bot      = 18'(hh) + 18'(half_h);
        if (bot >= 18'(cfg.screen_height))
            end_v = (cfg.screen_height == '0) ? 10'd0 : cfg.screen_height - 1'b1;
        else
            end_v = bot[9:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:  if (q_valid) state_next = q_data.hit ? BK_MUL : BK_DONE;
            BK_MUL:   state_next = BK_DSET;
            BK_DSET:  state_next = sat ? BK_HSET : BK_DDIV;
            BK_DDIV:  if (div_last) state_next = BK_HSET;
            BK_HSET:  state_next = (dist_reg == '0) ? BK_MSET : BK_HDIV;
            BK_HDIV:  if (div_last) state_next = BK_MSET;
            BK_MSET:  state_next = (dist_reg >= cfg.render_distance) ? BK_BLEND : BK_MDIV;
            BK_MDIV:  if (div_last) state_next = BK_BLEND;
            BK_BLEND: state_next = BK_DONE;
            BK_DONE:  if (out_free) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = (state_reg == BK_IDLE) && q_valid;
        out_load  = (state_reg == BK_DONE) && out_free;
        out_valid = out_valid_reg;
        res       = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load) out_reg <= res_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    ent_reg <= q_data;
                    if (!q_data.hit) res_reg <= '0;
                end
            end
            BK_MUL: n_reg <= N_W'(ent_reg.t * ent_reg.vc);
            BK_DSET:
            begin
                if (sat)
                begin
                    dist_reg <= 16'hFFFF;
                end
                else
                begin
                    rem_reg  <= REM_W'(n_reg[N_W-1:16]);
                    num_reg  <= {n_reg[15:0], 2'b00};
                    div_reg  <= dden;
                    quo_reg  <= '0;
                    dcnt_reg <= DCNT_W'(DIST_STEPS);
                end
            end
            BK_HSET:
            begin
                if (dist_reg == '0)
                begin
                    h_reg <= '1;
                end
                else
                begin
                    rem_reg  <= '0;
                    num_reg  <= {cfg.screen_height, 8'h00};
                    div_reg  <= REM_W'(dist_reg);
                    quo_reg  <= '0;
                    dcnt_reg <= DCNT_W'(H_STEPS);
                end
            end
            BK_MSET:
            begin
                if (dist_reg >= cfg.render_distance)
                begin
                    mix_reg <= 9'd256;
                end
                else
                begin
                    rem_reg  <= REM_W'(dist_reg);
                    num_reg  <= '0;
                    div_reg  <= REM_W'(cfg.render_distance);
                    quo_reg  <= '0;
                    dcnt_reg <= DCNT_W'(MIX_STEPS);
                end
            end
            BK_DDIV, BK_HDIV, BK_MDIV:
            begin
                rem_reg  <= rem_nx;
                num_reg  <= num_reg << 1;
                quo_reg  <= quo_nx;
                dcnt_reg <= dcnt_reg - 1'b1;
                if (div_last)
                begin
                    if (state_reg == BK_DDIV)      dist_reg <= quo_nx[15:0];
                    else if (state_reg == BK_HDIV) h_reg    <= quo_nx;
                    else                           mix_reg  <= {1'b0, quo_nx[7:0]};
                end
            end
            BK_BLEND:
            begin
                res_reg.hit        <= 1'b1;
                res_reg.side       <= ent_reg.side;
                res_reg.cell_x     <= ent_reg.cx;
                res_reg.cell_y     <= ent_reg.cy;
                res_reg.distance   <= dist_reg;
                res_reg.draw_start <= start_v;
                res_reg.draw_end   <= end_v;
                res_reg.fog_mix    <= mix_reg;
                res_reg.red   <= blend(cfg.wall_color[23:16], cfg.fog_color[23:16], mix_reg);
                res_reg.green <= blend(cfg.wall_color[15:8], cfg.fog_color[15:8], mix_reg);
                res_reg.blue  <= blend(cfg.wall_color[7:0], cfg.fog_color[7:0], mix_reg);
            end
            BK_DONE: ;
            default: ;
        endcase
    end

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DDIV || state_reg == BK_HDIV || state_reg == BK_MDIV)
        |-> dcnt_reg != '0)
        else $error("divider running with zero step count");

    a_mix_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_BLEND) |-> mix_reg <= 9'd256)
        else $error("fog weight above full fog");

    a_pop_next: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == BK_MUL || state_reg == BK_DONE))
        else $error("popped entry not taken up");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

### hw/rtl/dda_grid_ray_caster_unit.sv
// ----------------------------------------------------------------------------
// DDA grid ray caster
// Casts one screen column's ray through a 16x16 wall map and shades it.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | content
//  in       | to block  | in_valid/in_stall  | pos_x pos_y dir_x dir_y view_cos
//  out      | from block| out_valid/out_stall| hit side cell, distance, span, fog, rgb
//  config   | to block  | APB psel/penable   | map rows, height, fog distance, colors
//
// A ray is taken in the idle state, then the walk runs the FR_MULX and FR_MULY multiply
// states, one grid step per cycle (up to MAX_STEPS) and a push into the queue, which
// waits while the queue is full; a new request is taken only once the ray is pushed.
// Shading a hit runs the one-bit-a-cycle divider for 16 distance bits, 18 height
// bits and 8 fog bits; a miss skips the divider and goes straight to the output.
// A two-entry queue lets the walk of the next ray overlap the shading.
// Reset empties the pipeline and loads the register defaults; no clearing pass.
// A stalled output holds its request while the block keeps working behind it.
// ----------------------------------------------------------------------------
module dda_grid_ray_caster_unit
    import dda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        pos_x,
    input  logic [15:0]        pos_y,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic [14:0]        view_cos,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic               side,
    output logic [3:0]         cell_x,
    output logic [3:0]         cell_y,
    output logic [15:0]        distance,
    output logic [9:0]         draw_start,
    output logic [9:0]         draw_end,
    output logic [8:0]         fog_mix,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue
);

    logic [3:0][63:0] map_reg;
    cfg_t             cfg_reg;
    reg_idx_t         idx;
    logic             wr;
    logic             q_push, q_full, q_pop, q_nonempty;
    qent_t            q_in, q_out;
    res_t             res;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[5:3]);
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg                 <= '0;
            cfg_reg.screen_height   <= H_RESET;
            cfg_reg.render_distance <= RD_RESET;
            cfg_reg.wall_color      <= WALL_RESET;
            cfg_reg.fog_color       <= FOG_RESET;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_MAP0:   map_reg[0] <= pwdata;
                REG_MAP1:   map_reg[1] <= pwdata;
                REG_MAP2:   map_reg[2] <= pwdata;
                REG_MAP3:   map_reg[3] <= pwdata;
                REG_HEIGHT: cfg_reg.screen_height   <= pwdata[9:0];
                REG_RDIST:  cfg_reg.render_distance <= pwdata[15:0];
                REG_WALL:   cfg_reg.wall_color      <= pwdata[23:0];
                REG_FOG:    cfg_reg.fog_color       <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MAP0:   prdata = map_reg[0];
            REG_MAP1:   prdata = map_reg[1];
            REG_MAP2:   prdata = map_reg[2];
            REG_MAP3:   prdata = map_reg[3];
            REG_HEIGHT: prdata = 64'(cfg_reg.screen_height);
            REG_RDIST:  prdata = 64'(cfg_reg.render_distance);
            REG_WALL:   prdata = 64'(cfg_reg.wall_color);
            REG_FOG:    prdata = 64'(cfg_reg.fog_color);
            default:    prdata = '0;
        endcase
    end

    dda_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .view_cos (view_cos),
        .map_bits (map_reg),
        .q_push   (q_push),
        .q_data   (q_in),
        .q_full   (q_full)
    );

    dda_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .nonempty  (q_nonempty)
    );

    dda_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_nonempty),
        .q_pop     (q_pop),
        .q_data    (q_out),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign hit        = res.hit;
    assign side       = res.side;
    assign cell_x     = res.cell_x;
    assign cell_y     = res.cell_y;
    assign distance   = res.distance;
    assign draw_start = res.draw_start;
    assign draw_end   = res.draw_end;
    assign fog_mix    = res.fog_mix;
    assign red        = res.red;
    assign green      = res.green;
    assign blue       = res.blue;

endmodule

### bench/tb_dda_grid_ray_caster_unit.sv
// ----------------------------------------------------------------------------
// DDA grid ray caster testbench
// Drives rays through several wall maps and register settings, predicts each
// column result in the bench and checks every output field in order, with
// random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_dda_grid_ray_caster_unit;
    import dda_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 1620;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int MAX_WAIT    = 17;

    typedef struct {
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic [14:0]        view_cos;
        logic               has_known;
        res_t               known;
    } ray_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [5:0]         paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [14:0]        view_cos;
    logic               out_valid;
    logic               out_stall;
    logic               hit;
    logic               side;
    logic [3:0]         cell_x;
    logic [3:0]         cell_y;
    logic [15:0]        distance;
    logic [9:0]         draw_start;
    logic [9:0]         draw_end;
    logic [8:0]         fog_mix;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;

    // Bench copy of the registers.
    logic [63:0] wall_map [4];
    logic [9:0]  scr_h;
    logic [15:0] fog_dist;
    logic [23:0] wall_rgb;
    logic [23:0] fog_rgb;

    res_t  pending_columns[$];
    int    errors;
    int    cycles;
    int    out_wait = 0;
    ray_t  dir_rays[$];

    dda_grid_ray_caster_unit u_top (.*);

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout", $time);
            $display("tb_dda_grid_ray_caster_unit: FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] mix_channel(int w, int f, int mix);
        int num;
        num = w * 256 + (f - w) * mix;
        return 8'(num / 256);
    endfunction

    function automatic res_t cast_column(ray_t r);
        res_t        res;
        longint      adx, ady, tx, ty, t_hit, a, dst, hgt;
        int          cx, cy, sx, sy, start, stop, mix, y;
        logic        sd, struck, go_x;
        res = '0;
        adx = r.dir_x < 0 ? -longint'(r.dir_x) : longint'(r.dir_x);
        ady = r.dir_y < 0 ? -longint'(r.dir_y) : longint'(r.dir_y);
        cx = r.pos_x >> 12;
        cy = r.pos_y >> 12;
        sx = r.dir_x < 0 ? -1 : 1;
        sy = r.dir_y < 0 ? -1 : 1;
        tx = r.dir_x < 0 ? r.pos_x[11:0] : 4096 - r.pos_x[11:0];
        ty = r.dir_y < 0 ? r.pos_y[11:0] : 4096 - r.pos_y[11:0];
        t_hit = 0;
        sd = 0;
        struck = 0;
        for (int i = 0; i < MAX_STEPS; i++)
        begin
            go_x = r.dir_x != 0 && (r.dir_y == 0 || tx * ady < ty * adx);
            if (go_x)
            begin
                t_hit = tx; tx += 4096; cx += sx; sd = 0;
            end
            else
            begin
                t_hit = ty; ty += 4096; cy += sy; sd = 1;
            end
            if (cx < 0 || cx > 15 || cy < 0 || cy > 15)
                break;
            y = cy;
            if (wall_map[y >> 2][16 * (y & 3) + cx])
            begin
                struck = 1;
                break;
            end
        end
        if (!struck)
            return res;
        a = sd ? ady : adx;
        if (a == 0)
            dst = 65535;
        else
        begin
            dst = (t_hit * r.view_cos) / (a * 16);
            if (dst > 65535)
                dst = 65535;
        end
        if (dst == 0)
        begin
            start = 0;
            stop = int'(scr_h) - 1;
        end
        else
        begin
            hgt = (longint'(scr_h) * 256) / dst;
            start = int'(scr_h / 2) - int'(hgt / 2);
            stop = int'(hgt / 2) + int'(scr_h / 2);
            if (start < 0)
                start = 0;
            if (stop >= int'(scr_h))
                stop = int'(scr_h) - 1;
        end
        if (stop < 0)
            stop = 0;
        mix = dst < fog_dist ? int'((dst * 256) / fog_dist) : 256;
        res.hit = 1'b1;
        res.side = sd;
        res.cell_x = 4'(cx);
        res.cell_y = 4'(cy);
        res.distance = 16'(dst);
        res.draw_start = 10'(start);
        res.draw_end = 10'(stop);
        res.fog_mix = 9'(mix);
        res.red = mix_channel(wall_rgb[23:16], fog_rgb[23:16], mix);
        res.green = mix_channel(wall_rgb[15:8], fog_rgb[15:8], mix);
        res.blue = mix_channel(wall_rgb[7:0], fog_rgb[7:0], mix);
        return res;
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 6'(8 * int'(idx));
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MAP0, REG_MAP1, REG_MAP2, REG_MAP3: wall_map[int'(idx)] = value;
            REG_HEIGHT: scr_h = value[9:0];
            REG_RDIST:  fog_dist = value[15:0];
            REG_WALL:   wall_rgb = value[23:0];
            default:    fog_rgb = value[23:0];
        endcase
    endtask

    // Waits until every column has come back and the pipeline has drained.
    task automatic drain_columns();
        in_valid <= 1'b0;
        while (pending_columns.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    // Valid stays high from one request to the next unless a gap is drawn.
    task automatic send_ray(ray_t r);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x <= r.pos_x;
        pos_y <= r.pos_y;
        dir_x <= r.dir_x;
        dir_y <= r.dir_y;
        view_cos <= r.view_cos;
        pending_columns.push_back(r.has_known ? r.known : cast_column(r));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_dir();
        case ($urandom_range(0, 7))
            0: return 16'sd0;
            1: return 16'sd16384;
            2: return -16'sd16384;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic ray_t rand_ray();
        ray_t r;
        r.pos_x = 16'($urandom);
        r.pos_y = 16'($urandom);
        r.dir_x = rand_dir();
        r.dir_y = rand_dir();
        r.view_cos = $urandom_range(0, 4) == 0 ? 15'($urandom_range(0, 1) * 16384)
                                             : 15'($urandom_range(0, 16384));
        r.has_known = 1'b0;
        return r;
    endfunction

    function automatic ray_t mk(int px, int py, int dx, int dy, int vc);
        ray_t r;
        r.pos_x = 16'(px);
        r.pos_y = 16'(py);
        r.dir_x = 16'(dx);
        r.dir_y = 16'(dy);
        r.view_cos = 15'(vc);
        r.has_known = 1'b0;
        r.known = '0;
        return r;
    endfunction

    function automatic logic [63:0] rand_map(int density);
        logic [63:0] m;
        for (int b = 0; b < 64; b++)
            m[b] = $urandom_range(0, 99) < density;
        return m;
    endfunction

    // Receiver: a stall length drawn per column, and in-order checking.
    always @(posedge clk)
    begin
        res_t got, want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{hit, side, cell_x, cell_y, distance, draw_start, draw_end,
                        fog_mix, red, green, blue};
                if (pending_columns.size() == 0)
                begin
                    $display("%0t unexpected column: actual %p", $time, got);
                    errors++;
                end
                else
                begin
                    want = pending_columns.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t column mismatch: expected %p actual %p",
                                 $time, want, got);
                        errors++;
                    end
                end
                out_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, MAX_WAIT);
            end
            else if (out_valid && out_wait > 0)
                out_wait--;
            out_stall <= (out_wait > 0);
        end
    end

    initial
    begin
        ray_t r;
        errors = 0;
        cycles = 0;
        rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_valid = 0; pos_x = '0; pos_y = '0; dir_x = '0; dir_y = '0; view_cos = '0;
        out_stall = 0;
        for (int i = 0; i < 4; i++)
            wall_map[i] = '0;
        scr_h = H_RESET;
        fog_dist = RD_RESET;
        wall_rgb = WALL_RESET;
        fog_rgb = FOG_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Empty map after reset: every ray misses, whatever its fields.
        r = mk(16'hFFFF, 0, 16384, -16384, 16384); r.has_known = 1; dir_rays.push_back(r);
        r = mk(0, 16'hFFFF, 0, 0, 0); r.has_known = 1; dir_rays.push_back(r);
        r = mk(16'h8800, 16'h8800, -16384, 0, 16383); r.has_known = 1; dir_rays.push_back(r);
        foreach (dir_rays[i]) send_ray(dir_rays[i]);
        drain_columns();

        // Border walls all around, with the default shading registers.
        write_reg(REG_MAP0, 64'h8001_8001_8001_FFFF);
        write_reg(REG_MAP1, 64'h8001_8001_8001_8001);
        write_reg(REG_MAP2, 64'h8001_8001_8001_8001);
        write_reg(REG_MAP3, 64'hFFFF_8001_8001_8001);
        dir_rays.delete();
        dir_rays.push_back(mk(16'h8800, 16'h8800, 16384, 0, 16384));
        dir_rays.push_back(mk(16'h8800, 16'h8800, -16384, 0, 16384));
        dir_rays.push_back(mk(16'h8800, 16'h8800, 0, 16384, 16384));
        dir_rays.push_back(mk(16'h8800, 16'h8800, 0, -16384, 0));
        dir_rays.push_back(mk(16'h8800, 16'h8800, 0, 0, 16384));     // both zero
        dir_rays.push_back(mk(16'h1000, 16'h1000, -16384, -16384, 16384));
        dir_rays.push_back(mk(16'h1FFF, 16'h1FFF, -1, 1, 16384));
        dir_rays.push_back(mk(16'hE000, 16'h7000, 1, 16384, 16384));
        dir_rays.push_back(mk(16'h7000, 16'h0800, 16384, 0, 16384));  // start in a wall
        dir_rays.push_back(mk(16'hEFFF, 16'h2000, 16384, 0, 1));
        foreach (dir_rays[i]) send_ray(dir_rays[i]);
        drain_columns();

        // Extremes of the shading registers.
        write_reg(REG_HEIGHT, 64'd1023);
        write_reg(REG_RDIST, 64'd1);
        write_reg(REG_WALL, 64'hFFFF_FFFF_FF00_00FF);
        write_reg(REG_FOG, 64'h0000_0000_00FF_FF00);
        dir_rays.delete();
        dir_rays.push_back(mk(16'h8800, 16'h8800, 16384, 0, 16384));
        dir_rays.push_back(mk(16'hE800, 16'h8800, 16384, 0, 0));     // zero distance
        dir_rays.push_back(mk(16'h8800, 16'h8800, 0, 16384, 16384));
        foreach (dir_rays[i]) send_ray(dir_rays[i]);
        drain_columns();
        write_reg(REG_HEIGHT, 64'd0);
        write_reg(REG_RDIST, 64'd0);
        dir_rays.delete();
        dir_rays.push_back(mk(16'h8800, 16'h8800, -16384, 0, 16384));
        dir_rays.push_back(mk(16'h8800, 16'h8800, 0, -16384, 0));
        foreach (dir_rays[i]) send_ray(dir_rays[i]);
        drain_columns();

        // Random phases, each with its own map and registers.
        for (int ph = 0; ph < 12; ph++)
        begin
            int d;
            d = ph % 4 == 0 ? 0 : (ph % 4 == 1 ? 100 : $urandom_range(3, 40));
            for (int m = 0; m < 4; m++)
                write_reg(reg_idx_t'(m), rand_map(d));
            write_reg(REG_HEIGHT, ph == 1 ? 64'd1 : 64'($urandom_range(0, 1023)));
            write_reg(REG_RDIST, ph == 2 ? 64'hFFFF : 64'($urandom));
            write_reg(REG_WALL, 64'($urandom));
            write_reg(REG_FOG, ph == 3 ? 64'hFFFFFF : 64'($urandom));
            for (int n = 0; n < N_RANDOM / 12; n++)
                send_ray(rand_ray());
            drain_columns();
        end

        if (errors == 0)
            $display("tb_dda_grid_ray_caster_unit: PASS");
        else
            $display("tb_dda_grid_ray_caster_unit: FAIL");
        $finish;
    end

endmodule
